>>> hw/rtl/pdh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pair distance histogram.
package pdh_pkg;

	localparam int LEN_W  = 20;
	localparam int COMP_W = 28;
	localparam int SUM_W  = 58;
	localparam int ROOT_W = 29;
	localparam int DQ_W   = 21;
	localparam int CNT_W  = 32;

	localparam logic [1:0] ST_COUNTED = 2'd0;
	localparam logic [1:0] ST_BEYOND  = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_READ    = 2'd3;

	localparam logic [2:0] CFG_BOX_X    = 3'd0;
	localparam logic [2:0] CFG_BOX_Y    = 3'd1;
	localparam logic [2:0] CFG_BOX_Z    = 3'd2;
	localparam logic [2:0] CFG_PERIODIC = 3'd3;
	localparam logic [2:0] CFG_CUTOFF   = 3'd4;
	localparam logic [2:0] CFG_BIN_W    = 3'd5;

	typedef enum logic [2:0] {
		DS_IDLE, DS_MUL, DS_SQ, DS_SUM, DS_SQRT, DS_DIV
	} dist_state_t;

	typedef enum logic [1:0] {
		TS_IDLE, TS_DIST, TS_MEM, TS_RES
	} top_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} hist_stat_t;

endpackage

>>> hw/rtl/pdh_dist.sv
`timescale 1ns / 1ps
// Distance unit: wrap, scale, square, iterative square root and bin divider.
module pdh_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [COORD_BITS-1:0]         ax,
	input  logic [COORD_BITS-1:0]         ay,
	input  logic [COORD_BITS-1:0]         az,
	input  logic [COORD_BITS-1:0]         bx,
	input  logic [COORD_BITS-1:0]         by,
	input  logic [COORD_BITS-1:0]         bz,
	input  logic [2:0]                    periodic,
	input  logic [pdh_pkg::LEN_W-1:0]     box_x,
	input  logic [pdh_pkg::LEN_W-1:0]     box_y,
	input  logic [pdh_pkg::LEN_W-1:0]     box_z,
	input  logic [pdh_pkg::LEN_W-1:0]     bin_width,
	output logic                          done,
	output logic [pdh_pkg::DQ_W-1:0]      dq8,
	output logic [pdh_pkg::DQ_W-1:0]      quo
);
	import pdh_pkg::*;

	localparam int DW = COORD_BITS + 2;
	localparam logic signed [DW-1:0] ONE  = {2'b01, {COORD_BITS{1'b0}}};
	localparam logic signed [DW-1:0] HALF = {3'b001, {(COORD_BITS-1){1'b0}}};

	dist_state_t state_q, state_d;

	logic [COORD_BITS-1:0] m_q [3];
	logic [COMP_W-1:0]     c_q [3];
	logic [2*COMP_W-1:0]   sq_q [3];
	logic [SUM_W-1:0]      rad_q;
	logic [ROOT_W+2:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [DQ_W-1:0]       dvd_q;
	logic [LEN_W-1:0]      drem_q;
	logic [DQ_W-1:0]       quo_q;
	logic [DQ_W-1:0]       dq8_q;
	logic [4:0]            cnt_q;
	logic                  done_q;

	logic [COORD_BITS-1:0] m_d [3];
	logic [LEN_W-1:0]      box [3];
	logic [ROOT_W+2:0]     rem_sh, trial;
	logic                  sq_take;
	logic [ROOT_W-1:0]     root_d;
	logic [ROOT_W+2:0]     rem_d;
	logic [LEN_W-1:0]      bw;
	logic [DQ_W-1:0]       dr_sh;
	logic                  dv_take;

	function automatic logic [COORD_BITS-1:0] wrap_mag(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b,
		input logic                  per
	);
		logic signed [DW-1:0] d;
		logic [DW-1:0]        mag;
		d = $signed({2'b00, b}) - $signed({2'b00, a});
		if (per) begin
			if (d > HALF)
				d = d - ONE;
			if (d <= -HALF)
				d = d + ONE;
		end
		mag = (d < 0) ? DW'(-d) : DW'(d);
		return mag[COORD_BITS-1:0];
	endfunction

	always_comb begin
		m_d[0] = wrap_mag(ax, bx, periodic[0]);
		m_d[1] = wrap_mag(ay, by, periodic[1]);
		m_d[2] = wrap_mag(az, bz, periodic[2]);
		box[0] = box_x;
		box[1] = box_y;
		box[2] = box_z;
		rem_sh  = {rem_q[ROOT_W:0], rad_q[SUM_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		sq_take = rem_sh >= trial;
		root_d  = {root_q[ROOT_W-2:0], sq_take};
		rem_d   = sq_take ? rem_sh - trial : rem_sh;
		bw      = (bin_width == '0) ? LEN_W'(1) : bin_width;
		dr_sh   = {drem_q, dvd_q[DQ_W-1]};
		dv_take = dr_sh >= {1'b0, bw};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DS_DIV) && (cnt_q == '0);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DS_IDLE: if (start) state_d = DS_MUL;
			DS_MUL:  state_d = DS_SQ;
			DS_SQ:   state_d = DS_SUM;
			DS_SUM:  state_d = DS_SQRT;
			DS_SQRT: if (cnt_q == '0) state_d = DS_DIV;
			DS_DIV:  if (cnt_q == '0) state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DS_IDLE: begin
				for (int i = 0; i < 3; i++)
					m_q[i] <= m_d[i];
			end
			DS_MUL: begin
				for (int i = 0; i < 3; i++)
					c_q[i] <= COMP_W'(((COORD_BITS+LEN_W)'(m_q[i]) *
						(COORD_BITS+LEN_W)'(box[i])) >> (COORD_BITS - 8));
			end
			DS_SQ: begin
				for (int i = 0; i < 3; i++)
					sq_q[i] <= (2*COMP_W)'(c_q[i]) * (2*COMP_W)'(c_q[i]);
			end
			DS_SUM: begin
				rad_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'(ROOT_W - 1);
			end
			DS_SQRT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= rem_d;
				root_q <= root_d;
				cnt_q  <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					dq8_q  <= root_d[ROOT_W-1:8];
					dvd_q  <= root_d[ROOT_W-1:8];
					drem_q <= '0;
					quo_q  <= '0;
					cnt_q  <= 5'(DQ_W - 1);
				end
			end
			DS_DIV: begin
				dvd_q  <= dvd_q << 1;
				drem_q <= dv_take ? LEN_W'(dr_sh - {1'b0, bw}) : LEN_W'(dr_sh);
				quo_q  <= {quo_q[DQ_W-2:0], dv_take};
				cnt_q  <= cnt_q - 5'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign dq8  = dq8_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/pdh_hist.sv
`timescale 1ns / 1ps
// Histogram memory with read-modify-write and a clearing pass after reset.
module pdh_hist #(
	parameter int DEPTH = 9216,
	parameter int AW    = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_clear,
	input  logic [AW-1:0]             req_addr,
	output pdh_pkg::hist_stat_t       stat,
	output logic [pdh_pkg::CNT_W-1:0] old_count
);
	import pdh_pkg::*;

	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] rdata_s1;
	logic             pend_s1;
	logic             clr_op_s1;
	logic [AW-1:0]    addr_s1;
	logic             clearing_q;
	logic [AW-1:0]    clr_addr_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [CNT_W-1:0] wdata;

	always_comb begin
		we    = clearing_q || pend_s1;
		waddr = clearing_q ? clr_addr_q : addr_s1;
		if (clearing_q || clr_op_s1)
			wdata = '0;
		else if (rdata_s1 == '1)
			wdata = rdata_s1;
		else
			wdata = rdata_s1 + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_s1  <= mem[req_addr];
		clr_op_s1 <= req_clear;
		addr_s1   <= req_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= req_valid && !clearing_q;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(DEPTH - 1))
					clearing_q <= 1'b0;
			end
		end
	end

	assign stat.busy = clearing_q;
	assign stat.done = pend_s1;
	assign old_count = rdata_s1;

endmodule

>>> hw/rtl/pair_distance_histogram.sv
`timescale 1ns / 1ps
// Top level of the pair distance histogram with its sequencer and registers.
// One request is processed at a time. The wrap of a pair request is taken at acceptance. The
// distance unit then runs the scaling multiply, squaring and sum, a square root that settles one
// bit per cycle and a restoring divider that forms the bin index. The sequencer then checks the
// result and issues the histogram read, the count is written back, and the output register is
// loaded. A pair that is not counted skips the memory. A read request goes through the memory,
// and a read outside the store skips it. The finished result waits in an output register while
// the next request is taken. A new request is accepted from the cycle after the result is loaded.
// While the output register still holds an unaccepted result, the block waits before loading
// the next one. After reset the block clears its memory, one entry per cycle, all of its
// NUM_TYPES*NUM_TYPES*NUM_BINS entries (9216 with the defaults), and accepts no request until it
// is done.
module pair_distance_histogram #(
	parameter int NUM_TYPES  = 3,
	parameter int NUM_BINS   = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [19:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [COORD_BITS-1:0] first_x,
	input  logic [COORD_BITS-1:0] first_y,
	input  logic [COORD_BITS-1:0] first_z,
	input  logic [COORD_BITS-1:0] second_x,
	input  logic [COORD_BITS-1:0] second_y,
	input  logic [COORD_BITS-1:0] second_z,
	input  logic [1:0]            first_type,
	input  logic [1:0]            second_type,
	input  logic [3:0]            read_pair_type,
	input  logic [9:0]            read_bin,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [3:0]            species_pair,
	output logic [9:0]            bin,
	output logic [19:0]           distance,
	output logic [31:0]           count
);
	import pdh_pkg::*;

	localparam int PAIRS = NUM_TYPES * NUM_TYPES;
	localparam int DEPTH = PAIRS * NUM_BINS;
	localparam int AW    = $clog2(DEPTH);

	logic [LEN_W-1:0] box_x_q, box_y_q, box_z_q, cutoff_q, bin_w_q;
	logic [2:0]       periodic_q;

	top_state_t state_q, state_d;
	logic       kind_q;
	logic [1:0] t1_q, t2_q;
	logic [3:0] ptype_q;

	logic [1:0]       res_status_q;
	logic [3:0]       res_ptype_q;
	logic [9:0]       res_bin_q;
	logic [19:0]      res_dist_q;
	logic [CNT_W-1:0] res_count_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [3:0]       species_pair_q;
	logic [9:0]       bin_q;
	logic [19:0]      distance_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             dist_done;
	logic [DQ_W-1:0]  dq8, quo;
	hist_stat_t       hstat;
	logic [CNT_W-1:0] old_count;
	logic             hreq, hclear;
	logic [AW-1:0]    haddr;
	logic             rd_ok, over_cut, pair_bad, load_out;
	logic [5:0]       ptype_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q    <= LEN_W'(25600);
			box_y_q    <= LEN_W'(25600);
			box_z_q    <= LEN_W'(25600);
			periodic_q <= 3'd7;
			cutoff_q   <= LEN_W'(2560);
			bin_w_q    <= LEN_W'(26);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BOX_X:    box_x_q    <= cfg_data;
				CFG_BOX_Y:    box_y_q    <= cfg_data;
				CFG_BOX_Z:    box_z_q    <= cfg_data;
				CFG_PERIODIC: periodic_q <= cfg_data[2:0];
				CFG_CUTOFF:   cutoff_q   <= cfg_data;
				CFG_BIN_W:    bin_w_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == TS_IDLE) && !hstat.busy;
	assign accept    = in_valid && in_ready;

	pdh_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && !kind),
		.ax        (first_x),
		.ay        (first_y),
		.az        (first_z),
		.bx        (second_x),
		.by        (second_y),
		.bz        (second_z),
		.periodic  (periodic_q),
		.box_x     (box_x_q),
		.box_y     (box_y_q),
		.box_z     (box_z_q),
		.bin_width (bin_w_q),
		.done      (dist_done),
		.dq8       (dq8),
		.quo       (quo)
	);

	pdh_hist #(.DEPTH(DEPTH), .AW(AW)) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (hreq),
		.req_clear (hclear),
		.req_addr  (haddr),
		.stat      (hstat),
		.old_count (old_count)
	);

	always_comb begin
		ptype_in = 6'(first_type) * 6'(NUM_TYPES) + 6'(second_type);
		rd_ok    = (32'(read_pair_type) < 32'(PAIRS)) && (32'(read_bin) < 32'(NUM_BINS));
		over_cut = dq8 > {1'b0, cutoff_q};
		pair_bad = (32'(t1_q) >= 32'(NUM_TYPES)) || (32'(t2_q) >= 32'(NUM_TYPES)) ||
			(32'(quo) >= 32'(NUM_BINS));
		load_out = !out_valid_q || out_ready;
		state_d  = state_q;
		hreq     = 1'b0;
		hclear   = 1'b0;
		haddr    = AW'(read_pair_type) * AW'(NUM_BINS) + AW'(read_bin);
		unique case (state_q)
			TS_IDLE: begin
				if (accept) begin
					if (!kind)
						state_d = TS_DIST;
					else if (rd_ok) begin
						state_d = TS_MEM;
						hreq    = 1'b1;
						hclear  = 1'b1;
					end else
						state_d = TS_RES;
				end
			end
			TS_DIST: begin
				haddr = AW'(ptype_q) * AW'(NUM_BINS) + AW'(quo);
				if (dist_done) begin
					if (!over_cut && !pair_bad) begin
						state_d = TS_MEM;
						hreq    = 1'b1;
					end else
						state_d = TS_RES;
				end
			end
			TS_MEM: if (hstat.done) state_d = TS_RES;
			TS_RES: if (load_out) state_d = TS_IDLE;
			default: state_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == TS_RES && load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= kind;
			t1_q        <= first_type;
			t2_q        <= second_type;
			ptype_q     <= ptype_in[3:0];
			res_ptype_q <= kind ? read_pair_type : ptype_in[3:0];
			res_bin_q   <= kind ? read_bin : 10'd0;
			res_dist_q  <= '0;
			res_count_q <= '0;
			res_status_q <= kind ? (rd_ok ? ST_READ : ST_DROPPED) : ST_COUNTED;
		end
		if (state_q == TS_DIST && dist_done) begin
			res_dist_q <= dq8[DQ_W-1] ? 20'hFFFFF : dq8[19:0];
			if (over_cut) begin
				res_status_q <= ST_BEYOND;
				res_bin_q    <= 10'd0;
			end else begin
				res_status_q <= pair_bad ? ST_DROPPED : ST_COUNTED;
				res_bin_q    <= (quo > DQ_W'(1023)) ? 10'd1023 : quo[9:0];
			end
		end
		if (state_q == TS_MEM && hstat.done && kind_q)
			res_count_q <= old_count;
		if (state_q == TS_RES && load_out) begin
			status_q       <= res_status_q;
			species_pair_q <= res_ptype_q;
			bin_q          <= res_bin_q;
			distance_q     <= res_dist_q;
			count_q        <= res_count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign species_pair = species_pair_q;
	assign bin          = bin_q;
	assign distance     = distance_q;
	assign count        = count_q;

endmodule

>>> verif/tb_pair_distance_histogram.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pair distance histogram, with its own distance and bin predictor.
module tb_pair_distance_histogram;
	import pdh_pkg::*;

	localparam int TYPES     = 3;
	localparam int BINS      = 1024;
	localparam int DEPTH     = TYPES * TYPES * BINS;
	localparam int SETTLE    = 80;
	localparam int IDLE_LIMIT = 30000;

	typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_op_t;

	typedef struct {
		job_op_t     op;
		logic        kind;
		logic [15:0] fx, fy, fz, sx, sy, sz;
		logic [1:0]  ft, st;
		logic [3:0]  rp;
		logic [9:0]  rb;
		logic [2:0]  ci;
		logic [19:0] cd;
	} job_t;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  ptype;
		logic [9:0]  bin;
		logic [19:0] len;
		logic [31:0] count;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic kind = 1'b0;
	logic [15:0] first_x = '0, first_y = '0, first_z = '0;
	logic [15:0] second_x = '0, second_y = '0, second_z = '0;
	logic [1:0] first_type = '0, second_type = '0;
	logic [3:0] read_pair_type = '0;
	logic [9:0] read_bin = '0;
	logic out_valid, out_ready = 1'b1;
	logic [1:0] status;
	logic [3:0] species_pair;
	logic [9:0] bin;
	logic [19:0] distance;
	logic [31:0] count;

	pair_distance_histogram dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [31:0] hist_model [DEPTH];
	logic [19:0] box_x, box_y, box_z, cut_len, bin_len;
	logic [2:0]  wrap_axes;

	job_t        work_q [$];
	bin_result_t awaited_results [$];
	int errors = 0, n_items = 0, n_counted = 0, n_beyond = 0, n_dropped = 0, n_reads = 0;

	function automatic longint unsigned axis_scaled(logic [15:0] a, logic [15:0] b,
			logic periodic, logic [19:0] box);
		longint d;
		longint unsigned m;
		d = longint'(b) - longint'(a);
		if (periodic) begin
			if (d > 32768) d -= 65536;
			if (d <= -32768) d += 65536;
		end
		m = (d < 0) ? -d : d;
		return (m * longint'(box)) >> 8;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bin_result_t predict_histogram_step(job_t j);
		bin_result_t r;
		longint unsigned cx, cy, cz, dq, bw, bi;
		int idx;
		r = '{ST_DROPPED, 4'd0, 10'd0, 20'd0, 32'd0};
		if (j.kind) begin
			r.ptype = j.rp;
			r.bin = j.rb;
			if (j.rp < TYPES * TYPES) begin
				idx = j.rp * BINS + j.rb;
				r.count = hist_model[idx];
				hist_model[idx] = '0;
				r.status = ST_READ;
			end
		end else begin
			cx = axis_scaled(j.fx, j.sx, wrap_axes[0], box_x);
			cy = axis_scaled(j.fy, j.sy, wrap_axes[1], box_y);
			cz = axis_scaled(j.fz, j.sz, wrap_axes[2], box_z);
			dq = root_floor(cx * cx + cy * cy + cz * cz) >> 8;
			bw = (bin_len == 0) ? 1 : bin_len;
			r.ptype = 4'(j.ft * TYPES + j.st);
			r.len = (dq > 20'hFFFFF) ? 20'hFFFFF : dq[19:0];
			if (dq > cut_len) begin
				r.status = ST_BEYOND;
			end else begin
				bi = dq / bw;
				if (j.ft < TYPES && j.st < TYPES && bi < BINS) begin
					idx = (j.ft * TYPES + j.st) * BINS + int'(bi);
					if (hist_model[idx] != 32'hFFFFFFFF) hist_model[idx]++;
					r.status = ST_COUNTED;
				end
				r.bin = (bi > 1023) ? 10'd1023 : bi[9:0];
			end
		end
		return r;
	endfunction

	function automatic void apply_register(logic [2:0] i, logic [19:0] v);
		case (i)
			CFG_BOX_X: box_x = v;
			CFG_BOX_Y: box_y = v;
			CFG_BOX_Z: box_z = v;
			CFG_PERIODIC: wrap_axes = v[2:0];
			CFG_CUTOFF: cut_len = v;
			CFG_BIN_W: bin_len = v;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
		errors++;
	endtask

	task automatic add_job(job_t j);
		work_q.insert(work_q.size(), j);
	endtask

	// Driver: one request at a time, a drawn gap after each, drains before register writes.
	int send_gap = 0;
	bit send_burst = 0;
	always @(posedge clk) begin
		job_t j;
		logic keep_in, keep_cfg, go_in, go_cfg;
		bin_result_t r;
		if (arst_n) begin
			keep_in = in_valid && !in_ready;
			keep_cfg = cfg_valid && !cfg_ready;
			go_in = 1'b0;
			go_cfg = 1'b0;
			if (in_valid && in_ready) begin
				j.op = JOB_ITEM; j.kind = kind;
				j.fx = first_x; j.fy = first_y; j.fz = first_z;
				j.sx = second_x; j.sy = second_y; j.sz = second_z;
				j.ft = first_type; j.st = second_type;
				j.rp = read_pair_type; j.rb = read_bin;
				r = predict_histogram_step(j);
				awaited_results.insert(awaited_results.size(), r);
				n_items++;
			end
			if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
			if (!keep_in && !keep_cfg) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (work_q.size() != 0) begin
					j = work_q[0];
					if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
					case (j.op)
						JOB_DRAIN: begin
							if (awaited_results.size() == 0 && !(in_valid && in_ready)) begin
								void'(work_q.pop_front());
								send_gap = SETTLE;
							end
						end
						JOB_CFG: begin
							void'(work_q.pop_front());
							go_cfg = 1'b1;
							cfg_index <= j.ci;
							cfg_data <= j.cd;
							send_gap = send_burst ? 0 : $urandom_range(0, 10);
						end
						default: begin
							void'(work_q.pop_front());
							go_in = 1'b1;
							kind <= j.kind;
							first_x <= j.fx; first_y <= j.fy; first_z <= j.fz;
							second_x <= j.sx; second_y <= j.sy; second_z <= j.sz;
							first_type <= j.ft; second_type <= j.st;
							read_pair_type <= j.rp; read_bin <= j.rb;
							send_gap = send_burst ? 0 : $urandom_range(0, 10);
						end
					endcase
				end
			end
			in_valid <= keep_in || go_in;
			cfg_valid <= keep_cfg || go_cfg;
		end
	end

	// Monitor: checks each result against the oldest prediction, stalls at random.
	int stall = 0;
	bit recv_burst = 0;
	always @(posedge clk) begin
		bin_result_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("unexpected result at %0t", $time);
					errors++;
				end else begin
					e = awaited_results.pop_front();
					if (status !== e.status) report_mismatch("status", status, e.status);
					if (species_pair !== e.ptype)
						report_mismatch("species_pair", species_pair, e.ptype);
					if (bin !== e.bin) report_mismatch("bin", bin, e.bin);
					if (distance !== e.len) report_mismatch("distance", distance, e.len);
					if (count !== e.count) report_mismatch("count", count, e.count);
					case (e.status)
						ST_COUNTED: n_counted++;
						ST_BEYOND: n_beyond++;
						ST_DROPPED: n_dropped++;
						default: n_reads++;
					endcase
				end
				if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
				stall = recv_burst ? 0 : $urandom_range(0, 10);
				out_ready <= (stall == 0);
			end else if (stall > 0) begin
				stall--;
				out_ready <= (stall == 0);
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic job_t pair_job(logic [15:0] fx, fy, fz, sx, sy, sz,
			logic [1:0] ft, st);
		job_t j;
		j = '{JOB_ITEM, 1'b0, fx, fy, fz, sx, sy, sz, ft, st, 4'd0, 10'd0, 3'd0, 20'd0};
		j.rp = 4'($urandom); j.rb = 10'($urandom);
		return j;
	endfunction

	function automatic job_t read_job(logic [3:0] rp, logic [9:0] rb);
		job_t j;
		j = pair_job(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 2'($urandom), 2'($urandom));
		j.kind = 1'b1; j.rp = rp; j.rb = rb;
		return j;
	endfunction

	task automatic settings(logic [19:0] bx, by, bz, logic [2:0] pm, logic [19:0] cu, bw);
		add_job('{op: JOB_DRAIN, default: '0});
		add_job('{op: JOB_CFG, ci: CFG_BOX_X, cd: bx, default: '0});
		add_job('{op: JOB_CFG, ci: CFG_BOX_Y, cd: by, default: '0});
		add_job('{op: JOB_CFG, ci: CFG_BOX_Z, cd: bz, default: '0});
		add_job('{op: JOB_CFG, ci: CFG_PERIODIC, cd: {17'd0, pm}, default: '0});
		add_job('{op: JOB_CFG, ci: CFG_CUTOFF, cd: cu, default: '0});
		add_job('{op: JOB_CFG, ci: CFG_BIN_W, cd: bw, default: '0});
	endtask

	task automatic random_phase(int n, int spread, int bin_span);
		logic [15:0] a [3];
		logic [15:0] b [3];
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 5) == 0)
					add_job(read_job(4'($urandom), 10'($urandom)));
				else
					add_job(read_job(4'($urandom_range(0, 8)),
						10'($urandom_range(0, bin_span))));
			end else begin
				for (int k = 0; k < 3; k++) begin
					a[k] = 16'($urandom);
					if ($urandom_range(0, 7) == 0) b[k] = 16'($urandom);
					else b[k] = a[k] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
				end
				add_job(pair_job(a[0], a[1], a[2], b[0], b[1], b[2],
					($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
					($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2))));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) hist_model[i] = '0;
		box_x = 20'd25600; box_y = 20'd25600; box_z = 20'd25600;
		wrap_axes = 3'd7; cut_len = 20'd2560; bin_len = 20'd26;

		add_job(pair_job(0, 0, 0, 0, 0, 0, 0, 0));
		add_job(pair_job(100, 200, 300, 100, 200, 300, 0, 0));
		add_job(read_job(0, 0));
		add_job(read_job(0, 0));
		add_job(pair_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 2, 2));
		add_job(pair_job(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 2));
		add_job(pair_job(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0, 1));
		add_job(pair_job(16'h8000, 0, 0, 0, 0, 0, 2, 0));
		add_job(pair_job(0, 0, 0, 16'd3000, 16'd1000, 0, 3, 0));
		add_job(pair_job(0, 0, 0, 16'd100, 0, 0, 1, 3));
		add_job(read_job(4'd9, 10'd0));
		add_job(read_job(4'd15, 10'd1023));
		add_job(read_job(4'd8, 10'd1023));
		add_job(read_job(4'd8, 10'd0));
		add_job(read_job(4'd2, 10'd0));
		settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 3'd0, 20'hFFFFF, 20'd1);
		add_job(pair_job(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1));
		add_job(pair_job(0, 0, 0, 0, 0, 16'd1, 1, 1));
		settings(20'd0, 20'd0, 20'd0, 3'd5, 20'd0, 20'd0);
		add_job(pair_job(16'd5, 16'd9, 16'hFFFF, 16'hFFFF, 0, 0, 2, 1));
		add_job(read_job(4'd7, 10'd0));

		settings(20'd25600, 20'd25600, 20'd25600, 3'd7, 20'd2560, 20'd26);
		random_phase(170, 4000, 110);
		settings(20'd12800, 20'd51200, 20'd25600, 3'd2, 20'd5120, 20'd1);
		random_phase(170, 4000, 1023);
		settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 3'd7, 20'hFFFFF, 20'hFFFFF);
		random_phase(150, 20000, 4);
		settings(20'd25600, 20'd0, 20'd25600, 3'd1, 20'd2560, 20'd0);
		random_phase(150, 2000, 1023);
		for (int p = 0; p < 4; p++) begin
			settings(20'($urandom_range(12800, 51200)), 20'($urandom_range(12800, 51200)),
				20'($urandom_range(12800, 51200)), 3'($urandom_range(0, 7)),
				20'($urandom_range(256, 5120)), 20'($urandom_range(1, 200)));
			random_phase(150, 4000, 200);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (work_q.size() == 0);
		@(posedge clk);
		while (in_valid || cfg_valid || awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d requests: %0d counted, %0d beyond cutoff, %0d dropped, %0d reads.",
			n_items, n_counted, n_beyond, n_dropped, n_reads);
		if (errors == 0 && awaited_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> pair_distance_histogram.f
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_dist.sv
hw/rtl/pdh_hist.sv
hw/rtl/pair_distance_histogram.sv
verif/tb_pair_distance_histogram.sv
